// File: rtl/core/i2p_pkg.sv
// Shared types, token codes and helpers for the infix-to-postfix converter.
`timescale 1ns / 1ps
`default_nettype none
package i2p_pkg;

  localparam int DEF_STACK_DEPTH = 32;
  localparam int DEF_TAG_WIDTH   = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int KIND_W   = 4;
  localparam int SKIND_W  = 3;
  localparam int STATUS_W = 2;
  localparam int PREC_W   = 2;

  localparam logic [KIND_W-1:0] KIND_OPERAND = 4'd0;
  localparam logic [KIND_W-1:0] KIND_ADD     = 4'd1;
  localparam logic [KIND_W-1:0] KIND_SUB     = 4'd2;
  localparam logic [KIND_W-1:0] KIND_MUL     = 4'd3;
  localparam logic [KIND_W-1:0] KIND_DIV     = 4'd4;
  localparam logic [KIND_W-1:0] KIND_LESS    = 4'd5;
  localparam logic [KIND_W-1:0] KIND_GREATER = 4'd6;
  localparam logic [KIND_W-1:0] KIND_LPAREN  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_RPAREN  = 4'd8;
  localparam logic [KIND_W-1:0] KIND_END     = 4'd9;

  localparam logic [SKIND_W-1:0] SKIND_LPAREN = 3'd7;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNM_RPAR = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNM_LPAR = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

  localparam logic [PREC_W-1:0] PREC_NONE = 2'd0;
  localparam logic [PREC_W-1:0] PREC_CMP  = 2'd1;
  localparam logic [PREC_W-1:0] PREC_ADD  = 2'd2;
  localparam logic [PREC_W-1:0] PREC_MUL  = 2'd3;

  typedef enum logic [2:0] {
    CLS_OPERAND,
    CLS_OPERATOR,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_END
  } tok_class_t;

  typedef struct packed {
    tok_class_t        cls;
    logic [KIND_W-1:0] kind;
    logic [PREC_W-1:0] prec;
  } tok_meta_t;

  localparam int META_W = $bits(tok_meta_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_LOOK
  } back_state_t;

  function automatic logic [PREC_W-1:0] prec_of(input logic [KIND_W-1:0] kind);
    logic [PREC_W-1:0] p;
    p = PREC_NONE;
    case (kind)
      KIND_ADD, KIND_SUB:     p = PREC_ADD;
      KIND_MUL, KIND_DIV:     p = PREC_MUL;
      KIND_LESS, KIND_GREATER: p = PREC_CMP;
      default:                p = PREC_NONE;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/i2p_front.sv
// Front end: input handshake and token classification.
`timescale 1ns / 1ps
`default_nettype none
module i2p_front #(
  parameter int TAG_WIDTH = i2p_pkg::DEF_TAG_WIDTH
) (
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [i2p_pkg::KIND_W-1:0]  in_token_kind,
  input  wire logic [TAG_WIDTH-1:0]        in_token_tag,
  input  wire logic                        q_full,
  output logic                             q_push,
  output i2p_pkg::tok_meta_t               q_meta,
  output logic [TAG_WIDTH-1:0]             q_tag
);
  import i2p_pkg::*;

  logic known;

  assign in_stall = q_full;
  assign q_tag    = in_token_tag;

  always_comb begin
    known       = 1'b1;
    q_meta.kind = in_token_kind;
    q_meta.prec = prec_of(in_token_kind);
    q_meta.cls  = CLS_OPERAND;
    unique case (in_token_kind) inside
      KIND_OPERAND: q_meta.cls = CLS_OPERAND;
      [KIND_ADD:KIND_GREATER]: q_meta.cls = CLS_OPERATOR;
      KIND_LPAREN: q_meta.cls = CLS_LPAREN;
      KIND_RPAREN: q_meta.cls = CLS_RPAREN;
      KIND_END: q_meta.cls = CLS_END;
      default: known = 1'b0;  // unused codes: drop
    endcase
  end

  assign q_push = in_valid && !q_full && known;

endmodule
`default_nettype wire

// File: rtl/core/i2p_queue.sv
// Short token queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module i2p_queue #(
  parameter int DATA_W = i2p_pkg::META_W + i2p_pkg::DEF_TAG_WIDTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] wdata,
  output logic                   full,
  output logic                   vld,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      rdata
);
  import i2p_pkg::*;

  logic [DATA_W-1:0] slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign vld   = (cnt_r != '0);
  assign rdata = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/i2p_back.sv
// Back end: operator stack, pop sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none
module i2p_back #(
  parameter int STACK_DEPTH = i2p_pkg::DEF_STACK_DEPTH,
  parameter int TAG_WIDTH   = i2p_pkg::DEF_TAG_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_vld,
  input  wire i2p_pkg::tok_meta_t            q_meta,
  input  wire logic [TAG_WIDTH-1:0]          q_tag,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [i2p_pkg::KIND_W-1:0]         out_kind,
  output logic [TAG_WIDTH-1:0]               out_tag,
  output logic [i2p_pkg::STATUS_W-1:0]       out_status,
  output logic                               out_last
);
  import i2p_pkg::*;

  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int ENT_W = SKIND_W + TAG_WIDTH;

  back_state_t state_r, state_nxt;

  logic [ENT_W-1:0] stack_mem [STACK_DEPTH];
  logic [ENT_W-1:0] rd_data_r;
  logic             mem_we;
  logic [ENT_W-1:0] mem_wdata;
  logic [IDX_W-1:0] rd_idx, wr_idx;

  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_dec;

  tok_meta_t          cur_meta_r, cur_meta_nxt;
  logic [TAG_WIDTH-1:0] cur_tag_r, cur_tag_nxt;

  logic                pend_vld_r, pend_vld_nxt;
  logic [KIND_W-1:0]   pend_kind_r, pend_kind_nxt;
  logic [TAG_WIDTH-1:0] pend_tag_r, pend_tag_nxt;
  logic [STATUS_W-1:0] pend_status_r, pend_status_nxt;

  logic                out_vld_r, out_vld_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [TAG_WIDTH-1:0] out_tag_r, out_tag_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  logic                 out_free;
  logic [KIND_W-1:0]    top_kind;
  logic [TAG_WIDTH-1:0] top_tag;
  logic                 stk_empty, stk_full, top_is_lp;

  // Decision of one DECIDE step
  logic                 res_req;
  logic [KIND_W-1:0]    res_kind;
  logic [TAG_WIDTH-1:0] res_tag;
  logic [STATUS_W-1:0]  res_status;
  logic [CNT_W-1:0]     act_cnt;
  logic                 act_push;
  back_state_t          act_state;

  assign cnt_dec   = cnt_r - CNT_W'(1);
  assign rd_idx    = stk_empty ? '0 : cnt_dec[IDX_W-1:0];
  assign wr_idx    = cnt_r[IDX_W-1:0];
  assign stk_empty = (cnt_r == '0);
  assign stk_full  = (cnt_r == CNT_W'(STACK_DEPTH));
  assign top_kind  = {1'b0, rd_data_r[ENT_W-1 -: SKIND_W]};
  assign top_tag   = rd_data_r[TAG_WIDTH-1:0];
  assign top_is_lp = (rd_data_r[ENT_W-1 -: SKIND_W] == SKIND_LPAREN);
  assign mem_wdata = {cur_meta_r.kind[SKIND_W-1:0], cur_tag_r};
  assign out_free  = !out_vld_r || !out_stall;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    cur_meta_nxt    = cur_meta_r;
    cur_tag_nxt     = cur_tag_r;
    pend_vld_nxt    = pend_vld_r;
    pend_kind_nxt   = pend_kind_r;
    pend_tag_nxt    = pend_tag_r;
    pend_status_nxt = pend_status_r;
    out_vld_nxt     = out_vld_r && out_stall;
    out_kind_nxt    = out_kind_r;
    out_tag_nxt     = out_tag_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    q_pop           = 1'b0;
    mem_we          = 1'b0;

    res_req    = 1'b0;
    res_kind   = cur_meta_r.kind;
    res_tag    = cur_tag_r;
    res_status = STATUS_OK;
    act_cnt    = cnt_r;
    act_push   = 1'b0;
    act_state  = ST_IDLE;

    unique case (cur_meta_r.cls)
      CLS_OPERAND: begin
        res_req = 1'b1;
      end
      CLS_OPERATOR: begin
        if (!stk_empty && !top_is_lp && (prec_of(top_kind) >= cur_meta_r.prec)) begin
          res_req   = 1'b1;
          res_kind  = top_kind;
          res_tag   = top_tag;
          act_cnt   = cnt_dec;
          act_state = ST_LOOK;
        end else if (stk_full) begin
          res_req    = 1'b1;
          res_status = STATUS_OVERFLOW;
          act_cnt    = '0;
        end else begin
          act_push = 1'b1;
          act_cnt  = cnt_r + CNT_W'(1);
        end
      end
      CLS_LPAREN: begin
        if (stk_full) begin
          res_req    = 1'b1;
          res_status = STATUS_OVERFLOW;
          act_cnt    = '0;
        end else begin
          act_push = 1'b1;
          act_cnt  = cnt_r + CNT_W'(1);
        end
      end
      CLS_RPAREN: begin
        if (stk_empty) begin
          res_req    = 1'b1;
          res_status = STATUS_UNM_RPAR;
        end else if (top_is_lp) begin
          act_cnt = cnt_dec;
        end else begin
          res_req   = 1'b1;
          res_kind  = top_kind;
          res_tag   = top_tag;
          act_cnt   = cnt_dec;
          act_state = ST_LOOK;
        end
      end
      CLS_END: begin
        if (stk_empty) begin
          res_req = 1'b1;
        end else if (top_is_lp) begin
          res_req    = 1'b1;
          res_status = STATUS_UNM_LPAR;
          act_cnt    = '0;
        end else begin
          res_req   = 1'b1;
          res_kind  = top_kind;
          res_tag   = top_tag;
          act_cnt   = cnt_dec;
          act_state = ST_LOOK;
        end
      end
      default: begin
        act_state = ST_IDLE;
      end
    endcase

    unique case (state_r)
      ST_IDLE: begin
        if (!pend_vld_r || out_free) begin
          if (pend_vld_r) begin
            out_vld_nxt    = 1'b1;
            out_kind_nxt   = pend_kind_r;
            out_tag_nxt    = pend_tag_r;
            out_status_nxt = pend_status_r;
            out_last_nxt   = 1'b1;
            pend_vld_nxt   = 1'b0;
          end
          if (q_vld) begin
            q_pop        = 1'b1;
            cur_meta_nxt = q_meta;
            cur_tag_nxt  = q_tag;
            state_nxt    = ST_DECIDE;
          end
        end
      end
      ST_LOOK: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!(res_req && pend_vld_r && !out_free)) begin
          if (res_req) begin
            if (pend_vld_r) begin
              out_vld_nxt    = 1'b1;
              out_kind_nxt   = pend_kind_r;
              out_tag_nxt    = pend_tag_r;
              out_status_nxt = pend_status_r;
              out_last_nxt   = 1'b0;
            end
            pend_vld_nxt    = 1'b1;
            pend_kind_nxt   = res_kind;
            pend_tag_nxt    = res_tag;
            pend_status_nxt = res_status;
          end
          mem_we    = act_push;
          cnt_nxt   = act_cnt;
          state_nxt = act_state;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_meta_r    <= cur_meta_nxt;
    cur_tag_r     <= cur_tag_nxt;
    pend_kind_r   <= pend_kind_nxt;
    pend_tag_r    <= pend_tag_nxt;
    pend_status_r <= pend_status_nxt;
    out_kind_r    <= out_kind_nxt;
    out_tag_r     <= out_tag_nxt;
    out_status_r  <= out_status_nxt;
    out_last_r    <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_idx] <= mem_wdata;
    end
    rd_data_r <= stack_mem[rd_idx];
  end

  assign out_valid  = out_vld_r;
  assign out_kind   = out_kind_r;
  assign out_tag    = out_tag_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule
`default_nettype wire

// File: rtl/core/infix_to_postfix_converter_top.sv
// Top level of the infix-to-postfix converter: front end, token queue, back end.
`timescale 1ns / 1ps
`default_nettype none
// Converts a stream of infix tokens into postfix order with an operator stack
// (shunting-yard). Operands pass straight through; operators pop stacked
// operators of equal or higher precedence (comparison 1, add/sub 2, mul/div 3)
// down to a left parenthesis and are then pushed; a right parenthesis pops to
// its partner; the end token flushes the stack and is echoed as an end marker.
// Unmatched parentheses and stack overflow return an error status and clear
// the stack. out_last marks the final result of each input item; codes 10 to
// 15 are accepted and dropped. Timing: the front end classifies an item in
// the cycle it is accepted and drops it into a two-entry queue, so input is
// taken whenever the queue has room. The back end fetches each item from the
// queue and takes one decision step, plus a look and a decision step per
// operator popped, as the stack is a memory with a registered read port and
// each pop must wait for the new top of stack to be read. Each result is held
// one step in a pending register so the last one can be flagged, and leaves
// through an output register; a stall on the output holds the back end only.
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = i2p_pkg::DEF_STACK_DEPTH,
  parameter int TAG_WIDTH   = i2p_pkg::DEF_TAG_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [i2p_pkg::KIND_W-1:0]    in_token_kind,
  input  wire logic [TAG_WIDTH-1:0]          in_token_tag,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [i2p_pkg::KIND_W-1:0]         out_kind,
  output logic [TAG_WIDTH-1:0]               out_tag,
  output logic [i2p_pkg::STATUS_W-1:0]       out_status,
  output logic                               out_last
);
  import i2p_pkg::*;

  localparam int Q_W = META_W + TAG_WIDTH;

  // Front end to queue
  logic                 q_push, q_full;
  tok_meta_t            fe_meta;
  logic [TAG_WIDTH-1:0] fe_tag;

  // Queue to back end
  logic                 q_vld, q_pop;
  logic [Q_W-1:0]       q_rdata;
  tok_meta_t            be_meta;
  logic [TAG_WIDTH-1:0] be_tag;

  i2p_front #(
    .TAG_WIDTH(TAG_WIDTH)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_token_kind (in_token_kind),
    .in_token_tag  (in_token_tag),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_meta        (fe_meta),
    .q_tag         (fe_tag)
  );

  i2p_queue #(
    .DATA_W(Q_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({fe_meta, fe_tag}),
    .full  (q_full),
    .vld   (q_vld),
    .pop   (q_pop),
    .rdata (q_rdata)
  );

  // Split the queue word back into token class and tag
  assign be_meta = tok_meta_t'(q_rdata[Q_W-1 -: META_W]);
  assign be_tag  = q_rdata[TAG_WIDTH-1:0];

  i2p_back #(
    .STACK_DEPTH(STACK_DEPTH),
    .TAG_WIDTH  (TAG_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_vld      (q_vld),
    .q_meta     (be_meta),
    .q_tag      (be_tag),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_tag    (out_tag),
    .out_status (out_status),
    .out_last   (out_last)
  );

endmodule
`default_nettype wire

// File: bench/i2p_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the infix-to-postfix converter: predicts the postfix stream and checks it.
module i2p_checker #(
  parameter int STACK_DEPTH = i2p_pkg::DEF_STACK_DEPTH,
  parameter int TAG_WIDTH   = i2p_pkg::DEF_TAG_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic [i2p_pkg::KIND_W-1:0]    in_token_kind,
  input  wire logic [TAG_WIDTH-1:0]          in_token_tag,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic [i2p_pkg::KIND_W-1:0]    out_kind,
  input  wire logic [TAG_WIDTH-1:0]          out_tag,
  input  wire logic [i2p_pkg::STATUS_W-1:0]  out_status,
  input  wire logic                          out_last,
  output int                                 error_count,
  output int                                 results_due
);
  import i2p_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [TAG_WIDTH-1:0] tag;
    logic [STATUS_W-1:0]  status;
    logic                 last;
  } postfix_tok_t;

  postfix_tok_t         postfix_due [$];
  logic [SKIND_W-1:0]   opstk_kind [STACK_DEPTH];
  logic [TAG_WIDTH-1:0] opstk_tag  [STACK_DEPTH];
  int                   opstk_count = 0;
  int                   fails = 0;
  int                   due = 0;

  assign error_count = fails;
  assign results_due = due;

  task automatic flag_error(input string what);
    fails++;
    $display("[%0t] i2p_checker: %s", $time, what);
  endtask

  function automatic logic [PREC_W-1:0] op_rank(input logic [SKIND_W-1:0] kind);
    case ({1'b0, kind})
      KIND_LESS, KIND_GREATER: return PREC_CMP;
      KIND_ADD, KIND_SUB:      return PREC_ADD;
      KIND_MUL, KIND_DIV:      return PREC_MUL;
      default:                 return PREC_NONE;
    endcase
  endfunction

  function automatic postfix_tok_t make_tok(input logic [KIND_W-1:0] kind,
                                            input logic [TAG_WIDTH-1:0] tag,
                                            input logic [STATUS_W-1:0] status);
    postfix_tok_t tok;
    tok.kind   = kind;
    tok.tag    = tag;
    tok.status = status;
    tok.last   = 1'b0;
    return tok;
  endfunction

  function automatic postfix_tok_t pop_operator();
    opstk_count--;
    return make_tok({1'b0, opstk_kind[opstk_count]}, opstk_tag[opstk_count], STATUS_OK);
  endfunction

  // Work out every result one accepted token causes and queue them in order.
  task automatic convert_token(input logic [KIND_W-1:0] kind, input logic [TAG_WIDTH-1:0] tag);
    postfix_tok_t        step_out [$];
    logic [PREC_W-1:0]   rank;
    logic [STATUS_W-1:0] end_status;
    rank       = op_rank(kind[SKIND_W-1:0]);
    end_status = STATUS_OK;
    if (kind == KIND_OPERAND) begin
      step_out.push_back(make_tok(kind, tag, STATUS_OK));
    end else if (kind <= KIND_LPAREN) begin
      if (kind != KIND_LPAREN) begin
        while (opstk_count > 0 && opstk_kind[opstk_count-1] != SKIND_LPAREN
               && op_rank(opstk_kind[opstk_count-1]) >= rank) begin
          step_out.push_back(pop_operator());
        end
      end
      if (opstk_count >= STACK_DEPTH) begin
        opstk_count = 0;
        step_out.push_back(make_tok(kind, tag, STATUS_OVERFLOW));
      end else begin
        opstk_kind[opstk_count] = kind[SKIND_W-1:0];
        opstk_tag[opstk_count]  = tag;
        opstk_count++;
      end
    end else if (kind == KIND_RPAREN) begin
      while (opstk_count > 0 && opstk_kind[opstk_count-1] != SKIND_LPAREN) begin
        step_out.push_back(pop_operator());
      end
      if (opstk_count == 0) begin
        step_out.push_back(make_tok(kind, tag, STATUS_UNM_RPAR));
      end else begin
        opstk_count--;
      end
    end else if (kind == KIND_END) begin
      while (opstk_count > 0 && end_status == STATUS_OK) begin
        if (opstk_kind[opstk_count-1] == SKIND_LPAREN) begin
          end_status  = STATUS_UNM_LPAR;
          opstk_count = 0;
        end else begin
          step_out.push_back(pop_operator());
        end
      end
      step_out.push_back(make_tok(KIND_END, tag, end_status));
    end
    if (step_out.size() > 0) begin
      step_out[step_out.size()-1].last = 1'b1;
    end
    foreach (step_out[i]) begin
      postfix_due.push_back(step_out[i]);
    end
  endtask

  always @(posedge clk) begin : watch
    postfix_tok_t want;
    postfix_tok_t got;
    if (!rst_n) begin
      opstk_count = 0;
      postfix_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        convert_token(in_token_kind, in_token_tag);
      end
      if (out_valid && !out_stall) begin
        got      = make_tok(out_kind, out_tag, out_status);
        got.last = out_last;
        if (postfix_due.size() == 0) begin
          flag_error($sformatf("unexpected result kind %0d tag %h status %0d last %b",
                               got.kind, got.tag, got.status, got.last));
        end else begin
          want = postfix_due.pop_front();
          if (got.kind !== want.kind || got.tag !== want.tag
              || got.status !== want.status || got.last !== want.last) begin
            flag_error($sformatf(
              "got kind %0d tag %h status %0d last %b, want kind %0d tag %h status %0d last %b",
              got.kind, got.tag, got.status, got.last,
              want.kind, want.tag, want.status, want.last));
          end
        end
      end
    end
    due = postfix_due.size();
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the infix-to-postfix converter: clock, reset, token stimulus and verdict.
module tb_top;
  import i2p_pkg::*;

  localparam int TAG_W        = DEF_TAG_WIDTH;
  localparam int DEPTH        = DEF_STACK_DEPTH;
  localparam int RANDOM_ITEMS = 320;
  localparam int CALM_ITEMS   = 60;    // closing stretch with no idling on either side
  localparam int TAIL_CYCLES  = 64;
  localparam int LIMIT_NS     = 5_000_000;

  // Opening sequence: every operator once, then parentheses, then the error cases.
  localparam logic [KIND_W-1:0] OPENING_KINDS [28] = '{
    // a + b * c - d / e < f > g, end: precedence and left association
    KIND_OPERAND, KIND_ADD, KIND_OPERAND, KIND_MUL, KIND_OPERAND, KIND_SUB, KIND_OPERAND,
    KIND_DIV, KIND_OPERAND, KIND_LESS, KIND_OPERAND, KIND_GREATER, KIND_OPERAND, KIND_END,
    // (a + b) * c, end: matched right paren that pops
    KIND_LPAREN, KIND_OPERAND, KIND_ADD, KIND_OPERAND, KIND_RPAREN, KIND_MUL, KIND_OPERAND,
    KIND_END,
    // a + b ): unmatched right paren after popping the add
    KIND_OPERAND, KIND_ADD, KIND_OPERAND, KIND_RPAREN,
    // ( end: unmatched left paren at the end of the expression
    KIND_LPAREN, KIND_END
  };

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  logic [KIND_W-1:0]  in_token_kind = KIND_OPERAND;
  logic [TAG_W-1:0]   in_token_tag  = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  logic [KIND_W-1:0]  out_kind;
  logic [TAG_W-1:0]   out_tag;
  logic [STATUS_W-1:0] out_status;
  logic               out_last;

  int error_count;
  int results_due;

  // Idling policy, changed by the stimulus process as the run goes on.
  int gap_pct    = 0;
  int stall_pct  = 0;
  bit calm       = 1'b0;
  int stall_hold = 0;
  int sent_items = 0;   // items with a meaningful kind; ignored codes do not count

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  infix_to_postfix_converter_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_token_kind (in_token_kind),
    .in_token_tag  (in_token_tag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_tag       (out_tag),
    .out_status    (out_status),
    .out_last      (out_last)
  );

  i2p_checker #(
    .STACK_DEPTH (DEPTH),
    .TAG_WIDTH   (TAG_W)
  ) postfix_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_token_kind (in_token_kind),
    .in_token_tag  (in_token_tag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_tag       (out_tag),
    .out_status    (out_status),
    .out_last      (out_last),
    .error_count   (error_count),
    .results_due   (results_due)
  );

  // Result side: raise the stall in bursts of random length; hold it low in the calm tail.
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (rst_n && !calm && $urandom_range(99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_hold <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [TAG_W-1:0] rand_tag();
    return TAG_W'($urandom);
  endfunction

  function automatic logic [KIND_W-1:0] rand_operator();
    return KIND_W'($urandom_range(KIND_ADD, KIND_GREATER));
  endfunction

  // Offer one item and hold it until taken. Called at a rising edge and returns at the
  // edge where the item is accepted. The stall is looked at on the falling edge before,
  // where it cannot be moving, so acceptance never hinges on event order at the edge.
  task automatic send_token(input logic [KIND_W-1:0] kind, input logic [TAG_W-1:0] tag);
    logic taken;
    if (!calm && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_token_kind <= kind;
    in_token_tag  <= tag;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    if (kind <= KIND_END) begin
      sent_items++;
    end
  endtask

  // Well-formed expression: terms joined by random operators, random parenthesis nesting,
  // closed off and ended, so the stack fills and drains in every pattern.
  task automatic send_expression(input int terms);
    int open;
    open = 0;
    for (int i = 0; i < terms; i++) begin
      while (open < 6 && $urandom_range(99) < 25) begin
        send_token(KIND_LPAREN, rand_tag());
        open++;
      end
      send_token(KIND_OPERAND, rand_tag());
      while (open > 0 && $urandom_range(99) < 30) begin
        send_token(KIND_RPAREN, rand_tag());
        open--;
      end
      if (i < terms - 1) begin
        send_token(rand_operator(), rand_tag());
      end
    end
    while (open > 0) begin
      send_token(KIND_RPAREN, rand_tag());
      open--;
    end
    send_token(KIND_END, rand_tag());
  endtask

  // Deep nesting: each level stacks a left paren and an operator, so past sixteen levels
  // the stack overflows and the closing parens that follow find nothing to match.
  task automatic send_deep(input int levels);
    for (int i = 0; i < levels; i++) begin
      send_token(KIND_LPAREN, rand_tag());
      send_token(KIND_OPERAND, rand_tag());
      send_token(rand_operator(), rand_tag());
    end
    send_token(KIND_OPERAND, rand_tag());
    for (int i = 0; i < levels; i++) begin
      send_token(KIND_RPAREN, rand_tag());
    end
    send_token(KIND_END, rand_tag());
  endtask

  // Noise: any code at all, unused ones included, in any order.
  task automatic send_noise(input int count);
    for (int i = 0; i < count; i++) begin
      send_token(KIND_W'($urandom_range(0, 2 ** KIND_W - 1)), rand_tag());
    end
  endtask

  initial begin : stimulus
    int opening_items;
    int pick;
    bit drained;
    logic [TAG_W-1:0] tag;
    drained = 1'b0;

    // hold reset, then release it for good
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Opening part under light idling on both sides; extreme tags on the first operands.
    gap_pct   = 20;
    stall_pct = 20;
    foreach (OPENING_KINDS[i]) begin
      tag = rand_tag();
      if (i == 0) begin
        tag = '1;
      end else if (i == 2) begin
        tag = '0;
      end
      send_token(OPENING_KINDS[i], tag);
    end
    // unused codes: accepted and dropped
    for (int k = KIND_END + 1; k < 2 ** KIND_W; k++) begin
      send_token(KIND_W'(k), rand_tag());
    end
    // fill the stack with left parens, then an operator that finds it full
    repeat (DEPTH) send_token(KIND_LPAREN, rand_tag());
    send_token(KIND_ADD, rand_tag());
    // a lone right paren on the empty stack, then an end with nothing stacked
    send_token(KIND_RPAREN, rand_tag());
    send_token(KIND_END, rand_tag());
    opening_items = sent_items;

    // Random part: mostly well-formed expressions, some deep nests, some noise.
    while (sent_items < opening_items + RANDOM_ITEMS) begin
      // rotate the idling pattern so that gaps land on every phase of the work
      case ((sent_items / 50) % 5)
        0: begin
          gap_pct   = 25;
          stall_pct = 25;
        end
        1: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 60;
          stall_pct = 50;
        end
        3: begin
          gap_pct   = 0;
          stall_pct = 40;
        end
        default: begin
          gap_pct   = 40;
          stall_pct = 0;
        end
      endcase
      calm = (sent_items >= opening_items + RANDOM_ITEMS - CALM_ITEMS);

      // once, halfway through: hold the input until every expected result is out
      if (!drained && sent_items >= opening_items + RANDOM_ITEMS / 2) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(negedge clk); while (results_due != 0);
        @(posedge clk);
      end

      pick = $urandom_range(99);
      if (pick < 70) begin
        send_expression($urandom_range(1, 8));
      end else if (pick < 82) begin
        send_deep($urandom_range(13, 18));
      end else begin
        send_noise($urandom_range(1, 6));
      end
    end

    // finish on an end token so that whatever noise left stacked is flushed out
    calm = 1'b1;
    send_expression($urandom_range(2, 6));
    in_valid <= 1'b0;

    // drain, then allow the block time for anything still in flight
    do @(negedge clk); while (results_due != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("infix_to_postfix_converter_top: match");
    end else begin
      $display("infix_to_postfix_converter_top: mismatch");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin : watchdog
    #(LIMIT_NS);
    $display("infix_to_postfix_converter_top: mismatch");
    $finish;
  end

endmodule
